// ===== rtl/edsr_pkg.sv =====
// shared types and constants of the der signature to raw converter
`default_nettype none

package edsr_pkg;

	// status codes of a result
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_SEQ    = 3'd1;
	localparam logic [2:0] ST_BAD_SEQ   = 3'd2;
	localparam logic [2:0] ST_NO_INT    = 3'd3;
	localparam logic [2:0] ST_BAD_COORD = 3'd4;
	localparam logic [2:0] ST_MALFORMED = 3'd5;

	// der tags and length forms
	localparam logic [7:0] TAG_SEQ     = 8'h30;
	localparam logic [7:0] TAG_INT     = 8'h02;
	localparam logic [7:0] LEN_LONG1   = 8'h81;
	localparam logic [7:0] LEN_SHORT   = 8'h80;
	localparam logic [7:0] SEQ_LEN_MIN = 8'd8;
	localparam logic [7:0] SEQ_LEN_MAX = 8'd137;

	// field size selection from the total signature length
	localparam logic [7:0] SLEN_FS24 = 8'd58;
	localparam logic [7:0] SLEN_FS28 = 8'd66;
	localparam logic [7:0] SLEN_FS32 = 8'd74;
	localparam logic [7:0] SLEN_FS40 = 8'd90;

	// field size and per-command result count fit the widest field of 64 bytes
	localparam int FB_W = 7;
	localparam logic [FB_W-1:0] FS_24 = 7'd24;
	localparam logic [FB_W-1:0] FS_28 = 7'd28;
	localparam logic [FB_W-1:0] FS_32 = 7'd32;
	localparam logic [FB_W-1:0] FS_40 = 7'd40;

	// command queue between parser and output expander
	localparam int QDEPTH = 4;
	localparam int QIDX_W = 2;
	localparam int QCNT_W = 3;

	typedef enum logic [8:0] {
		PH_SEQ_TAG     = 9'b000000001,
		PH_SEQ_LEN     = 9'b000000010,
		PH_SEQ_LEN_EXT = 9'b000000100,
		PH_INT_TAG     = 9'b000001000,
		PH_INT_LEN     = 9'b000010000,
		PH_INT_LEN_EXT = 9'b000100000,
		PH_INT_DROP    = 9'b001000000,
		PH_INT_VALUE   = 9'b010000000,
		PH_IDLE        = 9'b100000000
	} phase_t;

	// one command: count results of the same byte, the final one may close the signature
	typedef struct packed {
		logic [7:0]      data;
		logic [2:0]      status;
		logic [FB_W-1:0] count;
		logic            last;
		logic [7:0]      res_len;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/edsr_front.sv =====
// der parser: takes one signature byte per transfer and issues output commands
`default_nettype none

module edsr_front #(
	parameter int MAX_FIELD_BYTES = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       sig_byte,
	input  wire logic [7:0]       sig_length,
	input  wire logic             last_byte,
	input  wire logic [7:0]       capacity,
	output logic                  push,
	output edsr_pkg::cmd_t        push_cmd
);
	import edsr_pkg::*;

	localparam logic [FB_W-1:0] FS_MAX = FB_W'(MAX_FIELD_BYTES);

	phase_t          phase_q, phase_d;
	logic [FB_W-1:0] fb_q, fb_d;
	logic            coord_q, coord_d;
	logic [7:0]      vl_q, vl_d;
	logic            first_q, first_d;

	logic [FB_W-1:0] fs_new, fs_eff, pad;
	logic [2:0]      err;
	logic            fin, int_go, cd, val_emit;
	logic [7:0]      vl_dec;

	always_comb begin
		priority if (sig_length <= SLEN_FS24) begin
			fs_new = FS_24;
		end else if (sig_length <= SLEN_FS28) begin
			fs_new = FS_28;
		end else if (sig_length <= SLEN_FS32) begin
			fs_new = FS_32;
		end else if (sig_length <= SLEN_FS40) begin
			fs_new = FS_40;
		end else begin
			fs_new = FS_MAX;
		end
	end

	assign fs_eff = first_q ? fs_new : fb_q;
	assign vl_dec = (vl_q != 8'd0) ? vl_q - 8'd1 : 8'd0;

	always_comb begin
		phase_d  = phase_q;
		fb_d     = fb_q;
		coord_d  = coord_q;
		vl_d     = vl_q;
		first_d  = first_q;
		err      = ST_OK;
		fin      = 1'b0;
		int_go   = 1'b0;
		cd       = 1'b0;
		val_emit = 1'b0;
		pad      = '0;
		push     = 1'b0;
		push_cmd = '{default: '0};

		if (accept && phase_q != PH_IDLE) begin
			first_d = 1'b0;
			if (first_q) begin
				fb_d = fs_new;
				if (capacity < {fs_new, 1'b0}) begin
					err = ST_MALFORMED;
				end
			end

			if (err == ST_OK) begin
				unique case (phase_q)
					PH_SEQ_TAG: begin
						if (sig_byte != TAG_SEQ) err = ST_NO_SEQ;
						else phase_d = PH_SEQ_LEN;
					end
					PH_SEQ_LEN: begin
						if (sig_byte < LEN_SHORT) begin
							if (sig_byte < SEQ_LEN_MIN || sig_byte > SEQ_LEN_MAX) err = ST_BAD_SEQ;
							else phase_d = PH_INT_TAG;
						end else if (sig_byte == LEN_LONG1) begin
							phase_d = PH_SEQ_LEN_EXT;
						end else begin
							err = ST_BAD_SEQ;
						end
					end
					PH_SEQ_LEN_EXT: begin
						if (sig_byte < SEQ_LEN_MIN || sig_byte > SEQ_LEN_MAX) err = ST_BAD_SEQ;
						else phase_d = PH_INT_TAG;
					end
					PH_INT_TAG: begin
						if (sig_byte != TAG_INT) err = ST_NO_INT;
						else phase_d = PH_INT_LEN;
					end
					PH_INT_LEN: begin
						if (sig_byte < LEN_SHORT) int_go = 1'b1;
						else if (sig_byte == LEN_LONG1) phase_d = PH_INT_LEN_EXT;
						else err = ST_MALFORMED;
					end
					PH_INT_LEN_EXT: begin
						int_go = 1'b1;
					end
					PH_INT_DROP: begin
						if (sig_byte != 8'h00) begin
							err = ST_BAD_COORD;
						end else begin
							vl_d    = {1'b0, fs_eff};
							phase_d = PH_INT_VALUE;
						end
					end
					PH_INT_VALUE: begin
						val_emit = 1'b1;
						vl_d     = vl_dec;
						if (vl_dec == 8'd0) cd = 1'b1;
					end
					default: begin
						err = ST_MALFORMED;
					end
				endcase

				// integer length: oversize check, leading zero drop or left padding
				if (int_go) begin
					if ({1'b0, sig_byte} > {2'b00, fs_eff} + 9'd1) begin
						err = ST_BAD_COORD;
					end else begin
						vl_d = sig_byte;
						if (sig_byte == {1'b0, fs_eff} + 8'd1) begin
							phase_d = PH_INT_DROP;
						end else begin
							if (sig_byte[6:0] < fs_eff && sig_byte[7] == 1'b0) begin
								pad = fs_eff - sig_byte[6:0];
							end
							if (sig_byte == 8'd0) cd = 1'b1;
							else phase_d = PH_INT_VALUE;
						end
					end
				end

				// coordinate complete: move on to s or finish
				if (cd) begin
					if (!coord_q) begin
						coord_d = 1'b1;
						phase_d = PH_INT_TAG;
					end else begin
						phase_d = PH_IDLE;
						fin     = 1'b1;
					end
				end
			end

			if (err == ST_OK && last_byte && !fin) begin
				err = ST_MALFORMED;
			end

			if (err != ST_OK) begin
				push             = 1'b1;
				push_cmd.status  = err;
				push_cmd.count   = FB_W'(1);
				push_cmd.last    = 1'b1;
				phase_d          = PH_IDLE;
			end else begin
				push_cmd.last    = fin;
				push_cmd.res_len = fin ? {fs_eff, 1'b0} : 8'd0;
				if (val_emit) begin
					push           = 1'b1;
					push_cmd.data  = sig_byte;
					push_cmd.count = FB_W'(1);
				end else if (pad != '0) begin
					push           = 1'b1;
					push_cmd.count = pad;
				end
			end
		end

		// last byte always readies the parser for a new signature
		if (accept && last_byte) begin
			phase_d = PH_SEQ_TAG;
			fb_d    = '0;
			coord_d = 1'b0;
			vl_d    = 8'd0;
			first_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEQ_TAG;
			fb_q    <= '0;
			coord_q <= 1'b0;
			vl_q    <= 8'd0;
			first_q <= 1'b1;
		end else begin
			phase_q <= phase_d;
			fb_q    <= fb_d;
			coord_q <= coord_d;
			vl_q    <= vl_d;
			first_q <= first_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/edsr_queue.sv =====
// short command queue between parser and output expander
`default_nettype none

module edsr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire edsr_pkg::cmd_t push_cmd,
	output logic                full,
	input  wire logic           pop,
	output edsr_pkg::cmd_t      pop_cmd,
	output logic                empty
);
	import edsr_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QIDX_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QIDX_W'(1);
			if (pop)  rd_q <= rd_q + QIDX_W'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue underflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("command queue count out of range");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
		else $error("command queue count did not advance");

endmodule

`default_nettype wire

// ===== rtl/edsr_back.sv =====
// output expander: turns each command into its run of result transfers
`default_nettype none

module edsr_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           empty,
	input  wire edsr_pkg::cmd_t pop_cmd,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          out_byte,
	output logic                out_last,
	output logic [2:0]          status,
	output logic [7:0]          result_length
);
	import edsr_pkg::*;

	cmd_t            cur_q;
	logic [FB_W-1:0] rem_q;
	logic            valid_q;
	logic            final_one, xfer;

	assign final_one = (rem_q == FB_W'(1));
	assign xfer      = valid_q && !out_stall;
	assign pop       = !empty && (!valid_q || (xfer && final_one));

	assign out_valid     = valid_q;
	assign out_byte      = cur_q.data;
	assign status        = cur_q.status;
	assign out_last      = cur_q.last && final_one;
	assign result_length = (cur_q.last && final_one) ? cur_q.res_len : 8'd0;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= '0;
		end else if (pop) begin
			valid_q <= 1'b1;
			rem_q   <= pop_cmd.count;
		end else if (xfer) begin
			if (final_one) begin
				valid_q <= 1'b0;
			end
			rem_q <= rem_q - FB_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ecdsa_der_signature_to_raw.sv =====
// top level of the der encoded ecdsa signature to raw r and s converter
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------------------
//  sig      | in        | sig_valid / sig_stall | sig_byte, sig_length, last_byte
//  out      | out       | out_valid / out_stall | out_byte, out_last, status, result_length
//  cfg      | in        | cfg_valid / cfg_ready | out_capacity
//
// one signature byte is taken per cycle while sig_stall is low; each byte yields
// no result, one result, or a burst of zero padding of up to MAX_FIELD_BYTES
// results, sent one per cycle unless out_stall holds the current result in place
// reset (arst_n low) clears parser state, the command queue and the output stage,
// and sets the capacity register to 128
// sig_stall rises only when the four-entry command queue is full, which happens
// while the expander works off a padding burst or the output side stalls; a
// command's first result is presented in the cycle after the expander pops it
`default_nettype none

module ecdsa_der_signature_to_raw #(
	parameter int MAX_FIELD_BYTES = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// signature bytes
	input  wire logic       sig_valid,
	output logic            sig_stall,
	input  wire logic [7:0] sig_byte,
	input  wire logic [7:0] sig_length,
	input  wire logic       last_byte,
	// raw results
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            out_last,
	output logic [2:0]      status,
	output logic [7:0]      result_length,
	// capacity register write
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] out_capacity
);
	import edsr_pkg::*;

	logic       accept, push, pop, full, empty;
	cmd_t       push_cmd, pop_cmd;
	logic [7:0] capacity_q;

	// the register is always writable, so writes must only come while the block is idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 8'd128;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= out_capacity;
		end
	end

	// a byte transfer happens whenever the queue has room for its command
	assign sig_stall = full;
	assign accept    = sig_valid && !sig_stall;

	// parser: classifies each byte and issues at most one command
	edsr_front #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.sig_byte   (sig_byte),
		.sig_length (sig_length),
		.last_byte  (last_byte),
		.capacity   (capacity_q),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// decouples parsing from padding bursts and output stalls
	edsr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	// expander: one result transfer per cycle from the head command unless out_stall is high
	edsr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (empty),
		.pop_cmd       (pop_cmd),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.out_last      (out_last),
		.status        (status),
		.result_length (result_length)
	);

endmodule

`default_nettype wire
